@@ rtl/ust_pkg.sv @@
// Package for the unique set table: sizes, action codes and sequencer states.
`timescale 1ns / 1ps

package ust_pkg;

	localparam int CAPACITY_DEFAULT    = 16;
	localparam int VALUE_WIDTH_DEFAULT = 32;
	localparam int ITEM_WIDTH          = 32;
	localparam int ACTION_WIDTH        = 2;
	localparam int ENTRY_COUNT_WIDTH   = 5;

	localparam logic [ACTION_WIDTH-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_WIDTH-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACTION_WIDTH-1:0] ACT_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT
	} ust_state_t;

endpackage

@@ rtl/unique_set_table.sv @@
// Unique set table: bounded ordered set of distinct values held in one entry memory.
`timescale 1ns / 1ps

// Usage
//   Request channel: action and item_value are taken at a rising edge with start high and
//   busy low. Actions: insert if absent, remove (first match, later entries shift down),
//   query; the unused code behaves as a query.
//   Result channel: done is high for exactly one cycle with was_present, entry_count and
//   full_drop. The receiver cannot stall; every result must be taken in its cycle.
// Timing
//   Entries live in a synchronous memory with one read and one write port. The search
//   reads one entry per cycle; a remove then moves one later entry per cycle, writing
//   entry j with entry j+1 (from the registered read port) while reading entry j+2.
//   Empty table: strobe in the cycle after the transfer, busy never rises.
//   Otherwise insert and query search from entry 0 up to the first match or the last
//   stored entry; a remove searches the same way and, on a hit below the last entry,
//   then moves every later entry down one place. The strobe follows the last busy cycle.
//   A new request may be transferred in the cycle its predecessor's strobe is shown.
// Reset
//   arst_n clears the count, the sequencer and the strobe. Entry contents are not cleared;
//   only entries below the count are ever used.
module unique_set_table #(
	parameter int CAPACITY    = ust_pkg::CAPACITY_DEFAULT,
	parameter int VALUE_WIDTH = ust_pkg::VALUE_WIDTH_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [ust_pkg::ACTION_WIDTH-1:0]      action,
	input  logic [ust_pkg::ITEM_WIDTH-1:0]        item_value,
	output logic                                  done,
	output logic                                  was_present,
	output logic [ust_pkg::ENTRY_COUNT_WIDTH-1:0] entry_count,
	output logic                                  full_drop
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

	// Entry memory: one write port, one registered read port.
	logic [VALUE_WIDTH-1:0] mem [CAPACITY];
	logic [VALUE_WIDTH-1:0] rd_data_q;
	logic [IDX_W-1:0]       rd_addr;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Sequencer state.
	ust_pkg::ust_state_t state_q, state_d;
	logic [CNT_W-1:0]                 count_q, count_d;
	logic [IDX_W-1:0]                 idx_q, idx_d;   // index whose data sits in rd_data_q during the search
	logic [ust_pkg::ACTION_WIDTH-1:0] act_q, act_d;
	logic [VALUE_WIDTH-1:0]           val_q, val_d;

	// Result registers.
	logic                                  done_q, done_d;
	logic                                  present_q, present_d;
	logic [ust_pkg::ENTRY_COUNT_WIDTH-1:0] count_out_q, count_out_d;
	logic                                  drop_q, drop_d;

	logic [VALUE_WIDTH-1:0] val_in;
	logic                   at_last;   // idx_q is the last stored entry
	logic                   hit;

	assign val_in  = VALUE_WIDTH'(item_value);
	assign at_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign hit     = (rd_data_q == val_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ust_pkg::ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q       <= idx_d;
		act_q       <= act_d;
		val_q       <= val_d;
		present_q   <= present_d;
		count_out_q <= count_out_d;
		drop_q      <= drop_d;
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		idx_d       = idx_q;
		act_d       = act_q;
		val_d       = val_q;
		done_d      = 1'b0;
		present_d   = present_q;
		count_out_d = count_out_q;
		drop_d      = drop_q;
		rd_addr     = '0;
		wr_en       = 1'b0;
		wr_addr     = count_q[IDX_W-1:0];
		wr_data     = val_q;

		unique case (state_q)
			ust_pkg::ST_IDLE: begin
				if (start) begin
					act_d = action;
					val_d = val_in;
					idx_d = '0;
					if (count_q == '0) begin
						// Empty table: answer at once, an insert goes to entry 0.
						done_d    = 1'b1;
						present_d = 1'b0;
						drop_d    = 1'b0;
						if (action == ust_pkg::ACT_INSERT) begin
							wr_en   = 1'b1;
							wr_addr = '0;
							wr_data = val_in;
							count_d = CNT_W'(1);
						end
						count_out_d = ust_pkg::ENTRY_COUNT_WIDTH'(count_d);
					end else begin
						state_d = ust_pkg::ST_SEARCH;
					end
				end
			end

			ust_pkg::ST_SEARCH: begin
				if (hit) begin
					present_d = 1'b1;
					drop_d    = 1'b0;
					if (act_q == ust_pkg::ACT_REMOVE && !at_last) begin
						// Close the gap: read the next entry, write it one place down.
						rd_addr = idx_q + IDX_W'(1);
						state_d = ust_pkg::ST_SHIFT;
					end else begin
						if (act_q == ust_pkg::ACT_REMOVE) begin
							count_d = count_q - CNT_W'(1);
						end
						done_d      = 1'b1;
						count_out_d = ust_pkg::ENTRY_COUNT_WIDTH'(count_d);
						state_d     = ust_pkg::ST_IDLE;
					end
				end else if (at_last) begin
					present_d = 1'b0;
					drop_d    = 1'b0;
					if (act_q == ust_pkg::ACT_INSERT) begin
						if (count_q == FULL_COUNT) begin
							drop_d = 1'b1;
						end else begin
							wr_en   = 1'b1;
							count_d = count_q + CNT_W'(1);
						end
					end
					done_d      = 1'b1;
					count_out_d = ust_pkg::ENTRY_COUNT_WIDTH'(count_d);
					state_d     = ust_pkg::ST_IDLE;
				end else begin
					rd_addr = idx_q + IDX_W'(1);
					idx_d   = idx_q + IDX_W'(1);
				end
			end

			ust_pkg::ST_SHIFT: begin
				// rd_data_q holds entry idx_q+1; idx_q is the write target.
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = rd_data_q;
				if ((CNT_W'(idx_q) + CNT_W'(2)) == count_q) begin
					count_d     = count_q - CNT_W'(1);
					done_d      = 1'b1;
					count_out_d = ust_pkg::ENTRY_COUNT_WIDTH'(count_d);
					state_d     = ust_pkg::ST_IDLE;
				end else begin
					rd_addr = idx_q + IDX_W'(2);
					idx_d   = idx_q + IDX_W'(1);
				end
			end

			default: begin
				state_d = ust_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy        = (state_q != ust_pkg::ST_IDLE);
	assign done        = done_q;
	assign was_present = present_q;
	assign entry_count = count_out_q;
	assign full_drop   = drop_q;

endmodule
